@@ rtl/piano_key_tone_burst_generator_macros.svh @@
// assertion macros shared by the tone burst generator checker
// no dependencies; include by bare file name
`ifndef PIANO_KEY_TONE_BURST_GENERATOR_MACROS_SVH
`define PIANO_KEY_TONE_BURST_GENERATOR_MACROS_SVH

// clocked assertion that is switched off while reset is held
`define PTBG_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// clocked assertion that also runs during reset
`define PTBG_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

@@ rtl/ptbg_pkg.sv @@
// shared constants for the piano key tone burst generator
// no dependencies; imported by every rtl module of the block
package ptbg_pkg;

  // command codes carried in tuser
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WHEEL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TRIGGER = 2'd2;

  // field widths
  localparam int DELTA_W  = 4;
  localparam int SAMPLE_W = 16;
  localparam int BURST_W  = 16;
  localparam int KEY_W    = 7;
  localparam int PHASE_W  = 32;

  // key range, equal temperament with A4 as key 49
  localparam logic [KEY_W-1:0] KEY_MIN = 7'd1;
  localparam logic [KEY_W-1:0] KEY_MAX = 7'd88;
  localparam logic [KEY_W-1:0] KEY_A4  = 7'd49;

  localparam logic [BURST_W-1:0] BURST_LEN_RESET = 16'd1000;

  // parameter defaults
  localparam int DEF_SINE_TABLE_BITS = 10;
  localparam int DEF_SAMPLE_RATE_HZ  = 8000;

  // pi/2 in Q30 radians
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // 2^(s/12) in Q2.30 for one octave of semitones
  localparam logic [31:0] SEMITONE_Q30 [12] = '{
    32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };

endpackage

@@ rtl/ptbg_inc_rom.sv @@
// phase increment table, one 32-bit step per piano key
// depends on ptbg_pkg (semitone ratios, widths)
module ptbg_inc_rom #(
  parameter int SAMPLE_RATE_HZ = ptbg_pkg::DEF_SAMPLE_RATE_HZ
) (
  input  logic [ptbg_pkg::KEY_W-1:0]   key,
  output logic [ptbg_pkg::PHASE_W-1:0] inc
);
  import ptbg_pkg::*;

  localparam int          KEYS = 1 << KEY_W;
  localparam logic [63:0] DEN  = 64'(16 * SAMPLE_RATE_HZ);

  logic [PHASE_W-1:0] inc_tab [KEYS];

  // 440 * 2^((k-49)/12) * 2^32 / fs, rounded to nearest
  for (genvar k = 0; k < KEYS; k++) begin : g_key
    localparam int          E   = k + 47;
    localparam int          SH0 = E / 12 - 2;
    localparam int          SH  = (SH0 > 9) ? 9 : SH0;
    localparam logic [63:0] NUM = (64'd440 * 64'(SEMITONE_Q30[E % 12])) << SH;
    localparam logic [63:0] INC = (NUM + DEN / 2) / DEN;
    assign inc_tab[k] = INC[PHASE_W-1:0];
  end

  assign inc = inc_tab[key];

endmodule

@@ rtl/ptbg_sine_rom.sv @@
// quarter-wave sine table with quadrant folding and registered read
// depends on ptbg_pkg (pi/2 constant, sample width)
module ptbg_sine_rom #(
  parameter int SINE_TABLE_BITS = ptbg_pkg::DEF_SINE_TABLE_BITS
) (
  input  logic                                clk,
  input  logic                                load,
  input  logic [SINE_TABLE_BITS-1:0]          phase_idx,
  output logic [ptbg_pkg::SAMPLE_W-1:0]       sample
);
  import ptbg_pkg::*;

  localparam int QBITS   = SINE_TABLE_BITS - 2;
  localparam int QUARTER = 1 << QBITS;

  logic [SAMPLE_W-2:0] sine_tab [QUARTER+1];
  logic [1:0]          quad;
  logic [QBITS-1:0]    r;
  logic [QBITS:0]      q_idx;
  logic [SAMPLE_W-2:0] mag_r;
  logic                neg_r;

  // table entries: Taylor series to x^13 in Q30, rounded to Q15
  for (genvar q = 0; q <= QUARTER; q++) begin : g_tab
    localparam logic [63:0] X  = (PI_HALF_Q30 * 64'(q) + 64'(QUARTER / 2)) >> QBITS;
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T1 = ((X  * X2) >> 30) / 6;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 20;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 42;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 72;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 110;
    localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 156;
    localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                           + longint'(T4) - longint'(T5) + longint'(T6);
    localparam longint MAG0 = (SUM < 0) ? 64'sd0 : ((SUM + 64'sd16384) >>> 15);
    localparam longint MAG  = (MAG0 > 64'sd32767) ? 64'sd32767 : MAG0;
    assign sine_tab[q] = MAG[SAMPLE_W-2:0];
  end

  // fold the phase into the first quadrant
  assign quad  = phase_idx[SINE_TABLE_BITS-1 -: 2];
  assign r     = phase_idx[QBITS-1:0];
  assign q_idx = quad[0] ? ((QBITS+1)'(QUARTER) - {1'b0, r}) : {1'b0, r};

  // registered table read
  always_ff @(posedge clk) begin
    if (load) begin
      mag_r <= sine_tab[q_idx];
      neg_r <= quad[1];
    end
  end

  // second half of the cycle is negative
  assign sample = neg_r ? SAMPLE_W'(-{1'b0, mag_r}) : {1'b0, mag_r};

endmodule

@@ rtl/piano_key_tone_burst_generator.sv @@
// Piano key sine tone burst generator, top level.
// Depends on ptbg_pkg, ptbg_inc_rom and ptbg_sine_rom.
//
// Input stream: in_tuser carries the command (sample tick, wheel step,
// trigger burst), in_tdata the signed wheel delta. A wheel step moves the
// key and clamps it to 1..88; a trigger loads the burst counter from the
// burst length register. Every sample tick yields exactly one word on the
// output stream, a signed Q1.15 sample that is zero outside a burst.
// Configuration: cfg_data is the burst length, taken whenever cfg_valid is
// high (cfg_ready is always high); write it only while the block is idle.
// Pipeline: a tick goes from the execute stage to the registered sine table
// read and then the output register. Throughput is one command per cycle
// unless stalled; key update, phase add and sine table index all sit in the
// one execute stage, whose loops are the key, phase and counter feedback.
// Stalls: when out_tready is low the output register holds its word, the
// sine stage and execute stage fill behind it and in_tready falls only once
// a tick can no longer move forward; wheel and trigger words still drain.
// Reset (rst_n low, synchronous): key 49, phase 0, no burst, burst length
// 1000, all pipeline stages empty.
module piano_key_tone_burst_generator #(
  parameter int SINE_TABLE_BITS = ptbg_pkg::DEF_SINE_TABLE_BITS,
  parameter int SAMPLE_RATE_HZ  = ptbg_pkg::DEF_SAMPLE_RATE_HZ
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,  // [3:0] wheel_delta
  input  logic [ptbg_pkg::CMD_W-1:0]      in_tuser,  // [1:0] cmd
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ptbg_pkg::SAMPLE_W-1:0]   out_tdata, // [15:0] tone_sample
  // burst length register
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptbg_pkg::BURST_W-1:0]    cfg_data
);
  import ptbg_pkg::*;

  // stage registers
  logic                s1_valid_r;
  logic [CMD_W-1:0]    cmd_r;
  logic [DELTA_W-1:0]  delta_r;
  logic                s2_valid_r;
  logic                sil_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_data_r;

  // block state
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [BURST_W-1:0]  burst_r, burst_nxt;
  logic [BURST_W-1:0]  burst_len_r;

  logic                out_free, s2_free, s1_go, tick_go, s2_move;
  logic signed [8:0]   key_sum;
  logic [PHASE_W-1:0]  inc;
  logic [SAMPLE_W-1:0] sine_sample;

  // handshake flow
  assign out_free  = !out_valid_r || out_tready;
  assign s2_free   = !s2_valid_r || out_free;
  assign s2_move   = s2_valid_r && out_free;
  assign s1_go     = s1_valid_r && ((cmd_r != CMD_TICK) || s2_free);
  assign tick_go   = s1_go && (cmd_r == CMD_TICK);
  assign in_tready = !s1_valid_r || s1_go;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ptbg_inc_rom #(
    .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
  ) u_inc_rom (
    .key(key_r),
    .inc(inc)
  );

  ptbg_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk      (clk),
    .load     (tick_go),
    .phase_idx(phase_r[PHASE_W-1 -: SINE_TABLE_BITS]),
    .sample   (sine_sample)
  );

  // key step with clamp
  assign key_sum = $signed({2'b00, key_r}) + $signed({{5{delta_r[DELTA_W-1]}}, delta_r});

  always_comb begin
    key_nxt   = key_r;
    phase_nxt = phase_r;
    burst_nxt = burst_r;
    case (cmd_r)
      CMD_TICK: begin
        if (burst_r != '0) begin
          phase_nxt = phase_r + inc;
          burst_nxt = burst_r - 1'b1;
        end
      end
      CMD_WHEEL: begin
        if (key_sum < $signed({2'b00, KEY_MIN})) begin
          key_nxt = KEY_MIN;
        end else if (key_sum > $signed({2'b00, KEY_MAX})) begin
          key_nxt = KEY_MAX;
        end else begin
          key_nxt = key_sum[KEY_W-1:0];
        end
      end
      CMD_TRIGGER: begin
        burst_nxt = burst_len_r;
      end
      default: begin
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      key_r       <= KEY_A4;
      phase_r     <= '0;
      burst_r     <= '0;
      burst_len_r <= BURST_LEN_RESET;
    end else begin
      if (cfg_valid) begin
        burst_len_r <= cfg_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_go) begin
        key_r   <= key_nxt;
        phase_r <= phase_nxt;
        burst_r <= burst_nxt;
      end
      if (tick_go) begin
        s2_valid_r <= 1'b1;
      end else if (out_free) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      cmd_r   <= in_tuser;
      delta_r <= in_tdata[DELTA_W-1:0];
    end
    if (tick_go) begin
      sil_r <= (burst_r == '0);
    end
    if (s2_move) begin
      out_data_r <= sil_r ? '0 : sine_sample;
    end
  end

endmodule

@@ rtl/ptbg_checker.sv @@
// port-level checker for the tone burst generator, bound to the top level
// depends on ptbg_pkg and piano_key_tone_burst_generator_macros.svh
`include "piano_key_tone_burst_generator_macros.svh"

module ptbg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [ptbg_pkg::CMD_W-1:0]    in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ptbg_pkg::SAMPLE_W-1:0] out_tdata
);
  import ptbg_pkg::*;

  // reset empties the output register
  `PTBG_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  // a stalled word stays put
  `PTBG_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "output word changed under stall")

  // a tick reaches the output when the sink keeps up
  `PTBG_ASSERT(a_tick_latency, clk, rst_n, (in_tvalid && in_tready && in_tuser == CMD_TICK) ##1 out_tready ##1 out_tready |=> out_tvalid, "tick sample late")

endmodule

bind piano_key_tone_burst_generator ptbg_checker u_ptbg_checker (.*);

@@ bench/ptbg_sample_checker.sv @@
// sample checker for the piano key tone burst generator
// watches the command, sample and burst length channels, predicts each sample
// depends on ptbg_pkg for the port widths and command codes
module ptbg_sample_checker #(
  parameter int SINE_TABLE_BITS = ptbg_pkg::DEF_SINE_TABLE_BITS,
  parameter int SAMPLE_RATE_HZ  = ptbg_pkg::DEF_SAMPLE_RATE_HZ
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // [3:0] wheel_delta
  input  logic [ptbg_pkg::CMD_W-1:0]    in_tuser,  // [1:0] cmd
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [ptbg_pkg::SAMPLE_W-1:0] out_tdata, // [15:0] tone_sample
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ptbg_pkg::BURST_W-1:0]  cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import ptbg_pkg::*;

  localparam int          QUARTER_BITS  = SINE_TABLE_BITS - 2;
  localparam int          LOWEST_KEY    = 1;
  localparam int          HIGHEST_KEY   = 88;
  localparam logic [6:0]  HOME_KEY      = 7'd49;
  localparam logic [15:0] DEFAULT_BURST = 16'd1000;
  localparam logic [63:0] QUARTER_TURN  = 64'd1686629713;  // pi/2 in Q30

  // one octave of equal temperament ratios, Q2.30
  localparam logic [31:0] OCTAVE_RATIO [12] = '{
    32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };

  // predicted block state and burst length register
  logic [6:0]  key;
  logic [31:0] phase;
  logic [15:0] burst_left;
  logic [15:0] burst_len;
  logic [15:0] samples_due [$];

  // phase step per sample for a key, rounded to nearest
  function automatic logic [31:0] tone_step(input logic [6:0] k);
    logic [63:0] e, octave, num, den;
    e = 64'(k) + 64'd47;
    octave = e / 64'd12 - 64'd2;
    if (octave > 64'd9) octave = 64'd9;
    num = (64'd440 * 64'(OCTAVE_RATIO[e % 64'd12])) << octave;
    den = 64'd16 * 64'(SAMPLE_RATE_HZ);
    return 32'((num + den / 64'd2) / den);
  endfunction

  // Q1.15 sine of the top phase bits, taylor series to x^13 in Q30
  function automatic logic [15:0] sine_sample(input logic [31:0] ph);
    logic [63:0] idx, quarter, quad, r, q, x, x2, term, div, mag;
    logic signed [63:0] acc;
    int n;
    idx = 64'(ph) >> (32 - SINE_TABLE_BITS);
    quarter = 64'd1 << QUARTER_BITS;
    quad = (idx >> QUARTER_BITS) & 64'd3;
    r = idx & (quarter - 64'd1);
    q = quad[0] ? quarter - r : r;
    x = (QUARTER_TURN * q + (quarter >> 1)) >> QUARTER_BITS;
    x2 = (x * x) >> 30;
    term = x;
    acc = $signed(x);
    for (n = 1; n <= 6; n++) begin
      div = 64'(2 * n) * 64'(2 * n + 1);
      term = ((term * x2) >> 30) / div;
      if (n % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    mag = ($unsigned(acc) + 64'd16384) >> 15;
    if (mag > 64'd32767) mag = 64'd32767;
    // second half of the cycle is negative
    if (quad[1]) return 16'd0 - mag[15:0];
    return mag[15:0];
  endfunction

  always @(posedge clk) begin
    logic [15:0]        want;
    logic signed [3:0]  delta;
    int                 next_key;
    if (!rst_n) begin
      key = HOME_KEY;
      phase = '0;
      burst_left = '0;
      burst_len = DEFAULT_BURST;
      samples_due.delete();
      fail_count = 0;
    end else begin
      // compare a sample word against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (samples_due.size() == 0) begin
          $error("tone_sample: no word expected, got %0d", $signed(out_tdata));
          fail_count++;
        end else begin
          want = samples_due.pop_front();
          if (out_tdata !== want) begin
            $error("tone_sample: expected %0d, got %0d", $signed(want),
                   $signed(out_tdata));
            fail_count++;
          end
        end
      end
      // burst length register write
      if (cfg_valid && cfg_ready) burst_len = cfg_data;
      // predict the effect of a command word
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          CMD_TICK: begin
            if (burst_left != 0) begin
              samples_due.push_back(sine_sample(phase));
              phase = phase + tone_step(key);
              burst_left = burst_left - 16'd1;
            end else begin
              samples_due.push_back(16'd0);
            end
          end
          CMD_WHEEL: begin
            delta = in_tdata[3:0];
            next_key = int'(key) + int'(delta);
            if (next_key < LOWEST_KEY) next_key = LOWEST_KEY;
            if (next_key > HIGHEST_KEY) next_key = HIGHEST_KEY;
            key = 7'(next_key);
          end
          CMD_TRIGGER: burst_left = burst_len;
          default: ;  // unused code, no effect
        endcase
      end
    end
    pending = samples_due.size();
  end

endmodule

@@ bench/tb_piano_key_tone_burst_generator.sv @@
// testbench top for the piano key tone burst generator
// drives command words and burst length writes, stalls the sample stream at random
// depends on ptbg_pkg, ptbg_sample_checker and the generator rtl
module tb_piano_key_tone_burst_generator;
  import ptbg_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int               PHASE_WORDS = 235;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [3:0] wheel_delta
  logic [CMD_W-1:0]    in_tuser;   // [1:0] cmd
  logic                out_tvalid;
  logic                out_tready;
  logic [SAMPLE_W-1:0] out_tdata;  // [15:0] tone_sample
  logic                cfg_valid;
  logic                cfg_ready;
  logic [BURST_W-1:0]  cfg_data;
  int                  mismatches;
  int                  samples_due;
  bit                  send_steady;
  bit                  take_steady;

  piano_key_tone_burst_generator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  ptbg_sample_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (mismatches),
    .pending    (samples_due)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // one command word, after a random gap
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [3:0] delta);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'd0, delta};
    do @(posedge clk); while (!in_tready);
  endtask

  // mostly ticks, so bursts play out, with wheel steps, retriggers and the unused code mixed in
  task automatic send_random_word();
    int unsigned pick;
    logic [CMD_W-1:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 68) cmd = CMD_TICK;
    else if (pick < 82) cmd = CMD_WHEEL;
    else if (pick < 94) cmd = CMD_TRIGGER;
    else cmd = CMD_UNUSED;
    send_word(cmd, 4'($urandom_range(0, 15)));
  endtask

  // stop sending and let every sample and any trailing command drain
  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (samples_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_burst_length(input logic [BURST_W-1:0] len);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // sample stream sink with random stalls
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    take_steady = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
      stall = take_steady ? 0 : $urandom_range(0, 10);
      repeat (stall) @(negedge clk) out_tready <= 1'b0;
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // stimulus and verdict
  initial begin
    logic [BURST_W-1:0] lengths [7];
    int i;
    int p;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_TICK;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    send_steady = 1'b0;
    lengths = '{16'd1, 16'd0, 16'd65535, 16'd6, 16'd40,
                16'($urandom_range(2, 300)), 16'd1000};
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: silence after reset, key clamped at both ends, unused code
    send_word(CMD_TICK, 4'h0);
    for (i = 0; i < 6; i++) send_word(CMD_WHEEL, 4'h7);
    send_word(CMD_TRIGGER, 4'h0);
    send_word(CMD_TICK, 4'h0);
    send_word(CMD_TICK, 4'hF);
    send_word(CMD_UNUSED, 4'hF);
    send_word(CMD_TICK, 4'h0);
    for (i = 0; i < 11; i++) send_word(CMD_WHEEL, 4'h8);
    send_word(CMD_TICK, 4'h0);
    send_word(CMD_TICK, 4'h0);

    // random phases, one burst length each
    for (p = 0; p < 7; p++) begin
      drain();
      write_burst_length(lengths[p]);
      for (i = 0; i < PHASE_WORDS; i++) send_random_word();
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ptbg_pkg.sv
rtl/ptbg_inc_rom.sv
rtl/ptbg_sine_rom.sv
rtl/piano_key_tone_burst_generator.sv
rtl/ptbg_checker.sv
bench/ptbg_sample_checker.sv
bench/tb_piano_key_tone_burst_generator.sv
